@@ design/tbp_pkg.sv @@
package tbp_pkg;

  localparam int GHIST_BITS = 9;
  localparam int LHIST_BITS = 10;
  localparam int PC_BITS    = 10;
  localparam int CTR_BITS   = 2;

  // sweep length covers the deepest table
  localparam int CLR_BITS_A = (GHIST_BITS > LHIST_BITS) ? GHIST_BITS : LHIST_BITS;
  localparam int CLR_BITS   = (CLR_BITS_A > PC_BITS) ? CLR_BITS_A : PC_BITS;

  localparam int IN_BITS  = 40;
  localparam int OUT_BITS = 8;
  localparam int TAKEN_BIT = 32;

  localparam logic [CTR_BITS-1:0] CTR_WEAK_NT = CTR_BITS'(1);
  localparam logic [CTR_BITS-1:0] CTR_MAX     = CTR_BITS'(3);
  localparam logic [CTR_BITS-1:0] CTR_MIN     = CTR_BITS'(0);

  typedef struct packed {
    logic [CTR_BITS-1:0] chooser;
    logic [CTR_BITS-1:0] dir;
  } glb_entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [GHIST_BITS-1:0] rd_addr;
    logic                  wr_en;
    logic [GHIST_BITS-1:0] wr_addr;
    glb_entry_t            wr_data;
  } glb_req_t;

  typedef struct packed {
    logic                  hist_rd_en;
    logic [PC_BITS-1:0]    hist_rd_addr;
    logic                  hist_wr_en;
    logic [PC_BITS-1:0]    hist_wr_addr;
    logic [LHIST_BITS-1:0] hist_wr_data;
    logic                  ctr_rd_en;
    logic [LHIST_BITS-1:0] ctr_rd_addr;
    logic                  ctr_wr_en;
    logic [LHIST_BITS-1:0] ctr_wr_addr;
    logic [CTR_BITS-1:0]   ctr_wr_data;
  } loc_req_t;

  function automatic logic [CTR_BITS-1:0] sat_step(input logic [CTR_BITS-1:0] ctr,
                                                   input logic up);
    logic [CTR_BITS-1:0] res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_MAX) res = ctr + CTR_BITS'(1);
    end else begin
      if (ctr != CTR_MIN) res = ctr - CTR_BITS'(1);
    end
    return res;
  endfunction

endpackage

@@ design/tbp_global_bank.sv @@
module tbp_global_bank (
  input  logic               clk,
  input  tbp_pkg::glb_req_t  req,
  output tbp_pkg::glb_entry_t rd_data
);

  // global direction counter and chooser share one row
  tbp_pkg::glb_entry_t mem [1 << tbp_pkg::GHIST_BITS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ design/tbp_local_bank.sv @@
module tbp_local_bank (
  input  logic                                clk,
  input  tbp_pkg::loc_req_t                   req,
  output logic [tbp_pkg::LHIST_BITS-1:0]      hist_rd_data,
  output logic [tbp_pkg::CTR_BITS-1:0]        ctr_rd_data
);

  logic [tbp_pkg::LHIST_BITS-1:0] hist_mem [1 << tbp_pkg::PC_BITS];
  logic [tbp_pkg::CTR_BITS-1:0]   ctr_mem  [1 << tbp_pkg::LHIST_BITS];

  always_ff @(posedge clk) begin
    if (req.hist_wr_en) begin
      hist_mem[req.hist_wr_addr] <= req.hist_wr_data;
    end
    if (req.hist_rd_en) begin
      hist_rd_data <= hist_mem[req.hist_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.ctr_wr_en) begin
      ctr_mem[req.ctr_wr_addr] <= req.ctr_wr_data;
    end
    if (req.ctr_rd_en) begin
      ctr_rd_data <= ctr_mem[req.ctr_rd_addr];
    end
  end

endmodule

@@ design/tournament_branch_predictor.sv @@
// channel  | dir | fields (lowest bit up)
// s_*      | in  | tdata: branch_pc[31:0], actual_taken[32], zero pad to 40 bits
// m_*      | out | tdata: predicted_taken[0], used_local[1], zero pad to 8 bits
//
// each branch steps through the idle, local and finish states: the local
// history read must land before the local counter read, and the finish state
// writes back all tables. after reset a clearing pass over 2**max(history, pc
// index bits) entries (1024 here) writes every table entry; s_tready stays low
// until it ends. the result sits in an output register; a full register with
// m_tready low holds the branch in the finish state until the word is taken.
module tournament_branch_predictor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tbp_pkg::IN_BITS-1:0]   s_tdata,   // branch_pc, actual_taken
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tbp_pkg::OUT_BITS-1:0]  m_tdata    // predicted_taken, used_local
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOCAL  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [tbp_pkg::CLR_BITS-1:0]   clr_idx;
  logic [tbp_pkg::GHIST_BITS-1:0] ghist;
  logic [tbp_pkg::GHIST_BITS-1:0] ghist_next;
  logic [tbp_pkg::PC_BITS-1:0]    pc_slot;
  logic                           taken;

  tbp_pkg::glb_req_t   glb_req;
  tbp_pkg::glb_entry_t glb_rd;
  tbp_pkg::loc_req_t   loc_req;
  logic [tbp_pkg::LHIST_BITS-1:0] lhist_rd;
  logic [tbp_pkg::CTR_BITS-1:0]   lctr_rd;
  logic [tbp_pkg::LHIST_BITS-1:0] lhist_next;

  logic accept;
  logic finish;
  logic g_pred;
  logic l_pred;
  logic use_local;
  logic pred;
  logic [tbp_pkg::CTR_BITS-1:0] chooser_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == ST_FINISH) && (!m_tvalid || m_tready);

  assign g_pred    = glb_rd.dir[tbp_pkg::CTR_BITS-1];
  assign l_pred    = lctr_rd[tbp_pkg::CTR_BITS-1];
  assign use_local = glb_rd.chooser[tbp_pkg::CTR_BITS-1];
  assign pred      = use_local ? l_pred : g_pred;

  // chooser only moves when exactly one side was right
  always_comb begin
    chooser_next = glb_rd.chooser;
    if ((g_pred != taken) && (l_pred == taken)) begin
      chooser_next = tbp_pkg::sat_step(glb_rd.chooser, 1'b1);
    end else if ((g_pred == taken) && (l_pred != taken)) begin
      chooser_next = tbp_pkg::sat_step(glb_rd.chooser, 1'b0);
    end
  end

  assign ghist_next = {ghist[tbp_pkg::GHIST_BITS-2:0], taken};
  assign lhist_next = {lhist_rd[tbp_pkg::LHIST_BITS-2:0], taken};

  always_comb begin
    glb_req.rd_en           = accept;
    glb_req.rd_addr         = ghist;
    glb_req.wr_en           = 1'b0;
    glb_req.wr_addr         = ghist;
    glb_req.wr_data.chooser = chooser_next;
    glb_req.wr_data.dir     = tbp_pkg::sat_step(glb_rd.dir, taken);

    loc_req.hist_rd_en   = accept;
    loc_req.hist_rd_addr = s_tdata[tbp_pkg::PC_BITS-1:0];
    loc_req.hist_wr_en   = 1'b0;
    loc_req.hist_wr_addr = pc_slot;
    loc_req.hist_wr_data = lhist_next;
    loc_req.ctr_rd_en    = (state == ST_LOCAL);
    loc_req.ctr_rd_addr  = lhist_rd;
    loc_req.ctr_wr_en    = 1'b0;
    loc_req.ctr_wr_addr  = lhist_rd;
    loc_req.ctr_wr_data  = tbp_pkg::sat_step(lctr_rd, taken);

    case (state)
      ST_CLEAR: begin
        glb_req.wr_en           = 1'b1;
        glb_req.wr_addr         = clr_idx[tbp_pkg::GHIST_BITS-1:0];
        glb_req.wr_data.chooser = tbp_pkg::CTR_WEAK_NT;
        glb_req.wr_data.dir     = tbp_pkg::CTR_WEAK_NT;
        loc_req.hist_wr_en      = 1'b1;
        loc_req.hist_wr_addr    = clr_idx[tbp_pkg::PC_BITS-1:0];
        loc_req.hist_wr_data    = '0;
        loc_req.ctr_wr_en       = 1'b1;
        loc_req.ctr_wr_addr     = clr_idx[tbp_pkg::LHIST_BITS-1:0];
        loc_req.ctr_wr_data     = tbp_pkg::CTR_WEAK_NT;
      end
      ST_FINISH: begin
        glb_req.wr_en      = finish;
        loc_req.hist_wr_en = finish;
        loc_req.ctr_wr_en  = finish;
      end
      default: begin
      end
    endcase
  end

  tbp_global_bank u_global (
    .clk     (clk),
    .req     (glb_req),
    .rd_data (glb_rd)
  );

  tbp_local_bank u_local (
    .clk          (clk),
    .req          (loc_req),
    .hist_rd_data (lhist_rd),
    .ctr_rd_data  (lctr_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      ghist    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + tbp_pkg::CLR_BITS'(1);
          if (&clr_idx) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOCAL;
          end
        end
        ST_LOCAL: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish) begin
            state <= ST_IDLE;
            ghist <= ghist_next;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_slot <= s_tdata[tbp_pkg::PC_BITS-1:0];
      taken   <= s_tdata[tbp_pkg::TAKEN_BIT];
    end
    if (finish) begin
      m_tdata <= {{(tbp_pkg::OUT_BITS-2){1'b0}}, use_local, pred};
    end
  end

endmodule
